// ===== hw/rtl/pdan_pkg.sv =====
// ----------------------------------------------------------------------------
// pdan_pkg: shared types and codes of the frame receiver
// Payload structs, configuration struct, result kinds and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pdan_pkg;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [2:0] REG_START_CHAR     = 3'd0;
  localparam logic [2:0] REG_ACK_CHAR       = 3'd1;
  localparam logic [2:0] REG_NACK_CHAR      = 3'd2;
  localparam logic [2:0] REG_MAX_LENGTH     = 3'd3;
  localparam logic [2:0] REG_CHECKSUM_SEED  = 3'd4;
  localparam logic [2:0] REG_TIMEOUT_ENABLE = 3'd5;
  localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd6;

  // Input mode codes
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_NACK    = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_START  = 3'd1;
  localparam logic [2:0] ST_TOO_LONG   = 3'd2;
  localparam logic [2:0] ST_CPL_BAD    = 3'd3;
  localparam logic [2:0] ST_CHKSUM_BAD = 3'd4;
  localparam logic [2:0] ST_TIMEOUT    = 3'd5;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } pdan_in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [7:0] payload_index;
    logic       last_payload;
    logic [2:0] status;
  } pdan_out_t;

  typedef struct packed {
    logic [7:0]  start_char;
    logic [7:0]  ack_char;
    logic [7:0]  nack_char;
    logic [7:0]  max_length;
    logic [7:0]  checksum_seed;
    logic        timeout_enable;
    logic [15:0] timeout_ticks;
  } pdan_cfg_t;

  // Command handed from front to back
  typedef struct packed {
    logic       is_tick;
    logic [7:0] data;
  } pdan_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pdan_front.sv =====
// ----------------------------------------------------------------------------
// pdan_front: input acceptance and classification
// Takes input transactions, drops ticks that cannot count and turns the rest
// into commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pdan_front import pdan_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire pdan_cfg_t cfg,
  input  wire logic      item_valid,
  output logic           item_stall,
  input  wire pdan_in_t  item,
  input  wire logic      queue_full,
  output logic           push,
  output pdan_cmd_t      push_cmd
);

  logic accept;

  // Hold the input off while the queue has no room
  assign item_stall = queue_full;
  assign accept     = item_valid && !queue_full;

  // Classify: a tick only matters when the timeout is enabled
  always_comb begin
    push_cmd.is_tick = (item.mode == MODE_TICK);
    push_cmd.data    = item.rx_byte;
    push             = accept && ((item.mode == MODE_BYTE) || cfg.timeout_enable);
  end

  // A queued command always comes from an accepted transaction
  assert property (@(posedge clk) disable iff (rst) push |-> item_valid && !item_stall)
    else $error("front pushed without an accepted transaction");

  assert property (@(posedge clk) disable iff (rst)
                   accept && item.mode == MODE_TICK && !cfg.timeout_enable |-> !push)
    else $error("disabled tick reached the queue");

  assert property (@(posedge clk) disable iff (rst)
                   accept && item.mode == MODE_BYTE |-> push && push_cmd.data == item.rx_byte)
    else $error("received byte not queued");

endmodule

`default_nettype wire

// ===== hw/rtl/pdan_queue.sv =====
// ----------------------------------------------------------------------------
// pdan_queue: short command queue between front and back
// Register-based circular buffer; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pdan_queue import pdan_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire pdan_cmd_t push_cmd,
  input  wire logic      pop,
  output logic           full,
  output logic           not_empty,
  output pdan_cmd_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pdan_cmd_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Store commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into a full queue");

  assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from an empty queue");

  assert property (@(posedge clk) disable iff (rst)
                   do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// ===== hw/rtl/pdan_back.sv =====
// ----------------------------------------------------------------------------
// pdan_back: frame state machine and result register
// Executes one queued command per cycle when not stalled, updates the frame
// state and loads payload, ACK or NACK results into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdan_back import pdan_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire pdan_cfg_t cfg,
  input  wire logic      cmd_valid,
  input  wire pdan_cmd_t cmd,
  output logic           cmd_pop,
  output logic           result_valid,
  input  wire logic      result_stall,
  output pdan_out_t      result
);

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_LEN   = 3'd1,
    PH_CPL   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHK   = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [8:0]  bytes_left, bytes_left_next;
  logic [7:0]  running_checksum, running_checksum_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [15:0] idle_ticks, idle_ticks_next;
  logic [15:0] idle_inc;
  logic        result_valid_next;
  pdan_out_t   result_next;
  logic        fire;
  logic        emit;
  logic        nack;
  logic [2:0]  nack_status;
  logic        last;

  // Take a command whenever the result register is free or being emptied
  assign fire    = cmd_valid && (!result_valid || !result_stall);
  assign cmd_pop = fire;

  always_comb begin
    phase_next            = phase;
    frame_length_next     = frame_length;
    bytes_left_next       = bytes_left;
    running_checksum_next = running_checksum;
    byte_position_next    = byte_position;
    idle_ticks_next       = idle_ticks;
    result_next           = result;
    emit                  = 1'b0;
    nack                  = 1'b0;
    nack_status           = ST_OK;
    last                  = (bytes_left <= 9'd1);
    idle_inc              = (idle_ticks != 16'hFFFF) ? idle_ticks + 1'b1 : idle_ticks;

    if (fire) begin
      if (cmd.is_tick) begin
        // Count the tick, time out when the limit is reached
        if (idle_inc >= cfg.timeout_ticks) begin
          idle_ticks_next = '0;
          nack            = 1'b1;
          nack_status     = ST_TIMEOUT;
        end else begin
          idle_ticks_next = idle_inc;
        end
      end else begin
        idle_ticks_next = '0;
        unique case (phase)
          PH_START: begin
            if (cmd.data != cfg.start_char) begin
              nack        = 1'b1;
              nack_status = ST_BAD_START;
            end else begin
              phase_next = PH_LEN;
            end
          end
          PH_LEN: begin
            if (cmd.data > cfg.max_length) begin
              nack        = 1'b1;
              nack_status = ST_TOO_LONG;
            end else begin
              frame_length_next = cmd.data;
              phase_next        = PH_CPL;
            end
          end
          PH_CPL: begin
            if (cmd.data != ~frame_length) begin
              nack        = 1'b1;
              nack_status = ST_CPL_BAD;
            end else begin
              bytes_left_next       = {1'b0, frame_length} + 9'd1;
              byte_position_next    = '0;
              running_checksum_next = cfg.checksum_seed;
              phase_next            = PH_DATA;
            end
          end
          PH_DATA: begin
            // Pass the payload byte on with its index
            running_checksum_next     = running_checksum ^ cmd.data;
            byte_position_next        = byte_position + 1'b1;
            bytes_left_next           = last ? '0 : bytes_left - 1'b1;
            if (last) begin
              phase_next = PH_CHK;
            end
            emit                      = 1'b1;
            result_next.out_kind      = KIND_PAYLOAD;
            result_next.out_byte      = cmd.data;
            result_next.payload_index = byte_position;
            result_next.last_payload  = last;
            result_next.status        = ST_OK;
          end
          PH_CHK: begin
            if (cmd.data != running_checksum) begin
              nack        = 1'b1;
              nack_status = ST_CHKSUM_BAD;
            end else begin
              phase_next                = PH_START;
              byte_position_next        = '0;
              emit                      = 1'b1;
              result_next.out_kind      = KIND_ACK;
              result_next.out_byte      = cfg.ack_char;
              result_next.payload_index = '0;
              result_next.last_payload  = 1'b0;
              result_next.status        = ST_OK;
            end
          end
          default: begin
            phase_next = PH_START;
          end
        endcase
      end

      // Reject: drop the frame and go back to waiting for the start character
      if (nack) begin
        phase_next                = PH_START;
        bytes_left_next           = '0;
        byte_position_next        = '0;
        emit                      = 1'b1;
        result_next.out_kind      = KIND_NACK;
        result_next.out_byte      = cfg.nack_char;
        result_next.payload_index = '0;
        result_next.last_payload  = 1'b0;
        result_next.status        = nack_status;
      end
    end

    // Keep a stalled result, clear a taken one
    if (fire && emit) begin
      result_valid_next = 1'b1;
    end else begin
      result_valid_next = result_valid && result_stall;
    end
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_START;
      frame_length     <= '0;
      bytes_left       <= '0;
      running_checksum <= '0;
      byte_position    <= '0;
      idle_ticks       <= '0;
      result_valid     <= 1'b0;
    end else begin
      phase            <= phase_next;
      frame_length     <= frame_length_next;
      bytes_left       <= bytes_left_next;
      running_checksum <= running_checksum_next;
      byte_position    <= byte_position_next;
      idle_ticks       <= idle_ticks_next;
      result_valid     <= result_valid_next;
    end
    result <= result_next;
  end

  assert property (@(posedge clk) disable iff (rst)
                   fire && nack |=> phase == PH_START && byte_position == '0)
    else $error("reject did not return to waiting for the start character");

  assert property (@(posedge clk) disable iff (rst)
                   result_valid && result.out_kind != KIND_PAYLOAD
                   |-> result.payload_index == '0 && !result.last_payload)
    else $error("reply carries payload index or last flag");

  assert property (@(posedge clk) disable iff (rst)
                   fire && !cmd.is_tick && phase == PH_DATA && last |=> phase == PH_CHK)
    else $error("last payload byte did not lead to the checksum phase");

  assert property (@(posedge clk) disable iff (rst)
                   result_valid && result.out_kind == KIND_PAYLOAD |-> result.status == ST_OK)
    else $error("payload result with an error status");

endmodule

`default_nettype wire

// ===== hw/rtl/packet_deframer_ack_nack.sv =====
// ----------------------------------------------------------------------------
// packet_deframer_ack_nack: frame receiver with XOR checksum and ACK/NACK
// Input channel (item_valid/item_stall/item) carries one received byte or one
// timer tick per transaction. Output channel (result_valid/result_stall/
// result) carries payload bytes with their index and ACK or NACK replies.
// A front stage accepts and classifies transactions and queues them
// (QUEUE_DEPTH entries); a back stage runs the frame state machine and loads
// a result register.
// Throughput: one transaction per cycle while the result register is not
// stalled. An accepted transaction passes through a queue entry, then the
// result register, before its result is valid.
// When the receiver stalls, the result register holds; the back stage stops
// taking commands, the queue fills and item_stall rises once it is full.
// Ticks arriving while the timeout is disabled are accepted and dropped.
// Reset (rst, synchronous) empties the queue, clears the frame state to
// waiting for the start character and restores the register defaults.
// Configuration registers sit on an APB port at byte address 4*index; write
// them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_deframer_ack_nack import pdan_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire pdan_in_t              item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output pdan_out_t                  result
);

  pdan_cfg_t  cfg;
  logic [2:0] reg_index;
  logic       cfg_write;
  logic       queue_full;
  logic       queue_not_empty;
  logic       push;
  logic       pop;
  pdan_cmd_t  push_cmd;
  pdan_cmd_t  head;

  assign pready    = 1'b1;
  assign reg_index = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_char     <= 8'd1;
      cfg.ack_char       <= 8'd6;
      cfg.nack_char      <= 8'd21;
      cfg.max_length     <= 8'd127;
      cfg.checksum_seed  <= 8'd0;
      cfg.timeout_enable <= 1'b1;
      cfg.timeout_ticks  <= 16'd1000;
    end else if (cfg_write) begin
      case (reg_index)
        REG_START_CHAR:     cfg.start_char     <= pwdata[7:0];
        REG_ACK_CHAR:       cfg.ack_char       <= pwdata[7:0];
        REG_NACK_CHAR:      cfg.nack_char      <= pwdata[7:0];
        REG_MAX_LENGTH:     cfg.max_length     <= pwdata[7:0];
        REG_CHECKSUM_SEED:  cfg.checksum_seed  <= pwdata[7:0];
        REG_TIMEOUT_ENABLE: cfg.timeout_enable <= pwdata[0];
        REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (reg_index)
      REG_START_CHAR:     prdata = CFG_DATA_W'(cfg.start_char);
      REG_ACK_CHAR:       prdata = CFG_DATA_W'(cfg.ack_char);
      REG_NACK_CHAR:      prdata = CFG_DATA_W'(cfg.nack_char);
      REG_MAX_LENGTH:     prdata = CFG_DATA_W'(cfg.max_length);
      REG_CHECKSUM_SEED:  prdata = CFG_DATA_W'(cfg.checksum_seed);
      REG_TIMEOUT_ENABLE: prdata = CFG_DATA_W'(cfg.timeout_enable);
      REG_TIMEOUT_TICKS:  prdata = CFG_DATA_W'(cfg.timeout_ticks);
      default:            prdata = '0;
    endcase
  end

  pdan_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  pdan_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head)
  );

  pdan_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd_valid    (queue_not_empty),
    .cmd          (head),
    .cmd_pop      (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
